### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NEXT(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### rtl/core/ngate_pkg.sv
// Package: types, constants and commands of the noise gate
package ngate_pkg;
	localparam int LEVEL_BITS_DEF = 24;
	localparam int COUNTER_BITS_DEF = 21;
	localparam int GAIN_BITS = 17;
	localparam logic [16:0] UNITY = 17'd65536;
	localparam logic [15:0] RMS_SCALE = 16'd46341;

	localparam logic [2:0] REG_UPPER = 3'd0;
	localparam logic [2:0] REG_LOWER = 3'd1;
	localparam logic [2:0] REG_ATTACK = 3'd2;
	localparam logic [2:0] REG_HOLD = 3'd3;
	localparam logic [2:0] REG_DECAY = 3'd4;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HOLD = 2'd1;
	localparam logic [1:0] PH_DECAY = 2'd2;

	typedef struct packed {
		logic signed [23:0] sample;
		logic [LEVEL_BITS_DEF-1:0] key_level;
	} in_word_t;

	typedef struct packed {
		logic signed [23:0] gated_sample;
		logic [16:0] gain;
		logic [1:0] gate_state;
	} out_word_t;

	typedef struct packed {
		logic [2:0] index;
		logic [31:0] data;
	} cfg_word_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input word, compute rms
		logic decide;    // run phase update
		logic div_start; // start ratio unit
		logic sq;        // square quotient
		logic mul;       // gain times sample
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_div;
		logic div_done;
	} dp_sts_t;
endpackage

### rtl/core/ngate_ctrl.sv
// Controller: sequences one word through the datapath
module ngate_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_take,
	output logic busy,
	output logic out_load,
	output ngate_pkg::dp_cmd_t cmd,
	input  ngate_pkg::dp_sts_t sts
);
	typedef enum logic [2:0] {S_IDLE, S_RMS, S_DEC, S_DIV, S_SQ, S_MUL, S_OUT} state_t;
	state_t state_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_take;
		cmd.decide = (state_q == S_DEC);
		cmd.div_start = (state_q == S_DEC) && sts.need_div;
		cmd.sq = (state_q == S_SQ);
		cmd.mul = (state_q == S_MUL);
		busy = (state_q != S_IDLE);
		out_load = (state_q == S_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_take) state_q <= S_RMS;
				S_RMS: state_q <= S_DEC;
				S_DEC: state_q <= sts.need_div ? S_DIV : S_MUL;
				S_DIV: if (sts.div_done) state_q <= S_SQ;
				S_SQ: state_q <= S_MUL;
				S_MUL: state_q <= S_OUT;
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### rtl/core/ngate_dp.sv
// Datapath: gate state, counters, ratio divider and gain multiply
module ngate_dp #(
	parameter int COUNTER_BITS = ngate_pkg::COUNTER_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  ngate_pkg::in_word_t in_word,
	input  logic [ngate_pkg::LEVEL_BITS_DEF-1:0] upper_q,
	input  logic [ngate_pkg::LEVEL_BITS_DEF-1:0] lower_q,
	input  logic [19:0] attack_q,
	input  logic [19:0] hold_q,
	input  logic [19:0] decay_q,
	input  ngate_pkg::dp_cmd_t cmd,
	output ngate_pkg::dp_sts_t sts,
	output logic signed [23:0] gated_q,
	output logic [16:0] gain_q,
	output logic [1:0] phase_q
);
	localparam int LEVEL_BITS = ngate_pkg::LEVEL_BITS_DEF;
	localparam int CB = COUNTER_BITS;
	localparam int WB = (CB > 20) ? CB : 20;     // compare width
	localparam logic [CB-1:0] CNT_MAX = '1;
	localparam longint HYST = ((64'd1 << (LEVEL_BITS - 4)) + 64'd5) / 64'd10;
	localparam int QB = 17;                        // quotient bits incl. guard
	localparam int DCB = $clog2(QB + 1);

	logic signed [23:0] sample_q;
	logic [LEVEL_BITS-1:0] key_q;
	logic [LEVEL_BITS:0] rms_q;    // one extra bit for hysteresis add
	logic [CB-1:0] att_q, hld_q, dcy_q;

	// divider state
	logic [WB+16:0] rem_q;
	logic [WB-1:0] den_q;
	logic [QB-1:0] quo_q;
	logic [DCB-1:0] dcnt_q;
	logic div_run_q;
	logic [WB-1:0] div_n, div_d;
	logic need_div;

	logic [LEVEL_BITS+15:0] rms_prod;
	assign rms_prod = {16'd0, key_q} * {{LEVEL_BITS{1'b0}}, ngate_pkg::RMS_SCALE};

	function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] c);
		return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
	endfunction

	function automatic logic [WB-1:0] wx(input logic [CB-1:0] c);
		return WB'(c);
	endfunction

	// next-state evaluation
	logic [1:0] ph_n;
	logic [CB-1:0] att_n, hld_n, dcy_n;
	logic [16:0] gain_n;
	logic [LEVEL_BITS:0] rms_h;
	logic [WB-1:0] a_w, h_w, d_w;

	always_comb begin
		ph_n = phase_q;
		att_n = att_q;
		hld_n = hld_q;
		dcy_n = dcy_q;
		gain_n = gain_q;
		need_div = 1'b0;
		div_n = '0;
		div_d = '0;
		a_w = WB'(attack_q);
		h_w = WB'(hold_q);
		d_w = WB'(decay_q);
		rms_h = rms_q;
		unique case (phase_q)
			ngate_pkg::PH_HOLD: begin
				if (rms_q > {1'b0, lower_q}) hld_n = '0;
				else if (wx(hld_q) < h_w) hld_n = sat_inc(hld_q);
				else begin
					ph_n = ngate_pkg::PH_DECAY;
					dcy_n = '0;
				end
				gain_n = ngate_pkg::UNITY;
			end
			ngate_pkg::PH_DECAY: begin
				if (rms_q > {1'b0, upper_q}) begin
					if (wx(att_q) > a_w) begin
						ph_n = ngate_pkg::PH_HOLD;
						hld_n = '0;
						att_n = '0;
						gain_n = ngate_pkg::UNITY;
					end else begin
						att_n = sat_inc(att_q);
						dcy_n = sat_inc(dcy_q);
						need_div = 1'b1;
						div_n = (wx(dcy_n) >= d_w) ? wx(dcy_n) - d_w : d_w - wx(dcy_n);
						div_d = d_w;
					end
				end else if (wx(dcy_q) > d_w) begin
					ph_n = ngate_pkg::PH_IDLE;
					gain_n = '0;
				end else if (dcy_q != '0) begin
					need_div = 1'b1;
					div_n = d_w - wx(dcy_q);
					div_d = d_w;
					dcy_n = sat_inc(dcy_q);
				end else begin
					dcy_n = sat_inc(dcy_q);
					gain_n = ngate_pkg::UNITY;
				end
			end
			default: begin
				ph_n = ngate_pkg::PH_IDLE;
				if (rms_q < {1'b0, upper_q} && att_q != '0)
					rms_h = rms_q + (LEVEL_BITS+1)'(HYST);
				if (rms_h > {1'b0, upper_q}) begin
					if (wx(att_q) > a_w) begin
						ph_n = ngate_pkg::PH_HOLD;
						hld_n = '0;
						att_n = '0;
						gain_n = ngate_pkg::UNITY;
					end else begin
						att_n = sat_inc(att_q);
						need_div = 1'b1;
						div_n = wx(att_n);
						div_d = a_w;
					end
				end else if (att_q != '0) begin
					if (wx(att_q) > h_w) begin
						ph_n = ngate_pkg::PH_HOLD;
						hld_n = '0;
						att_n = '0;
						gain_n = ngate_pkg::UNITY;
					end else begin
						ph_n = ngate_pkg::PH_DECAY;
						dcy_n = att_q;
						hld_n = '0;
						att_n = '0;
						need_div = 1'b1;
						div_n = wx(att_q);
						div_d = a_w;
					end
				end else begin
					gain_n = '0;
				end
			end
		endcase
		// clamp cases need no division
		if (need_div && (div_d == '0 || div_n >= div_d)) begin
			need_div = 1'b0;
			gain_n = ngate_pkg::UNITY;
		end
	end

	assign sts.need_div = need_div;
	assign sts.div_done = div_run_q && (dcnt_q == '0);

	logic [WB+16:0] trial;
	assign trial = {rem_q[WB+15:0], 1'b0};

	logic [33:0] sq_prod;
	assign sq_prod = {17'd0, quo_q} * {17'd0, quo_q};

	logic signed [41:0] smul;
	assign smul = 42'(sample_q) * $signed({25'd0, gain_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ngate_pkg::PH_IDLE;
			att_q <= '0;
			hld_q <= '0;
			dcy_q <= '0;
			gain_q <= '0;
			div_run_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			if (cmd.decide) begin
				phase_q <= ph_n;
				att_q <= att_n;
				hld_q <= hld_n;
				dcy_q <= dcy_n;
				gain_q <= gain_n;
			end
			if (cmd.div_start) begin
				div_run_q <= 1'b1;
				dcnt_q <= DCB'(QB);
			end else if (div_run_q) begin
				if (dcnt_q == '0) div_run_q <= 1'b0;
				else dcnt_q <= dcnt_q - 1'b1;
			end
			if (cmd.sq) gain_q <= sq_prod[32:16];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= in_word.sample;
			key_q <= in_word.key_level[LEVEL_BITS-1:0];
		end
		rms_q <= {1'b0, rms_prod[LEVEL_BITS+15:16]};
		if (cmd.div_start) begin
			// restoring division of n*2^16 by d; quotient fits 16 bits since n < d
			rem_q <= (WB+17)'(div_n);
			den_q <= div_d;
			quo_q <= '0;
		end else if (div_run_q && dcnt_q != '0) begin
			if (dcnt_q == DCB'(QB)) begin
				rem_q <= rem_q;
			end else if (trial >= {17'd0, den_q}) begin
				rem_q <= trial - {17'd0, den_q};
				quo_q <= {quo_q[QB-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[QB-2:0], 1'b0};
			end
		end
		if (cmd.mul) gated_q <= smul[39:16];
	end
endmodule

### rtl/core/noise_gate_attack_hold_decay_top.sv
// Noise gate: one word is processed at a time; when the squared ratio is
// needed it goes through the 16-step restoring divider, then the square. The
// next word is taken once the controller is idle and the result register is
// free. Control and configuration registers reset to zero; gate starts idle.
`include "assert_macros.svh"
module noise_gate_attack_hold_decay_top #(
	parameter int COUNTER_BITS = ngate_pkg::COUNTER_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  ngate_pkg::in_word_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output ngate_pkg::out_word_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  ngate_pkg::cfg_word_t cfg
);
	localparam int LEVEL_BITS = ngate_pkg::LEVEL_BITS_DEF;

	logic [LEVEL_BITS-1:0] upper_q, lower_q;
	logic [19:0] attack_q, hold_q, decay_q;
	logic busy, out_load, in_take;
	ngate_pkg::dp_cmd_t cmd;
	ngate_pkg::dp_sts_t sts;
	logic signed [23:0] gated;
	logic [16:0] gain;
	logic [1:0] phase;

	assign cfg_ready = 1'b1;
	assign in_stall = busy || out_valid;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= '0;
			lower_q <= '0;
			attack_q <= '0;
			hold_q <= '0;
			decay_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg.index)
				ngate_pkg::REG_UPPER: upper_q <= LEVEL_BITS'(cfg.data[23:0]);
				ngate_pkg::REG_LOWER: lower_q <= LEVEL_BITS'(cfg.data[23:0]);
				ngate_pkg::REG_ATTACK: attack_q <= cfg.data[19:0];
				ngate_pkg::REG_HOLD: hold_q <= cfg.data[19:0];
				ngate_pkg::REG_DECAY: decay_q <= cfg.data[19:0];
				default: ;
			endcase
		end
	end

	ngate_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_take(in_take), .busy(busy),
		.out_load(out_load), .cmd(cmd), .sts(sts)
	);

	ngate_dp #(.COUNTER_BITS(COUNTER_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(in_data),
		.upper_q(upper_q), .lower_q(lower_q), .attack_q(attack_q),
		.hold_q(hold_q), .decay_q(decay_q), .cmd(cmd), .sts(sts),
		.gated_q(gated), .gain_q(gain), .phase_q(phase)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data.gated_sample <= gated;
			out_data.gain <= gain;
			out_data.gate_state <= phase;
		end
	end

	`ASSERT_IMPL(a_no_take_busy, clk, arst_n, busy, !in_take)
	`ASSERT_IMPL(a_gain_max, clk, arst_n, out_valid, out_data.gain <= ngate_pkg::UNITY)
	`ASSERT_NEXT(a_take_busy, clk, arst_n, in_take, busy)
endmodule

### tb/gate_checker.sv
// Checker: watches the gate's channels, predicts each result word and compares
`timescale 1ns / 100ps
module gate_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  ngate_pkg::in_word_t in_data,
	input  logic out_valid,
	input  logic out_stall,
	input  ngate_pkg::out_word_t out_data,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  ngate_pkg::cfg_word_t cfg,
	output int fail_count,
	output int pending
);
	localparam logic [20:0] CNT_SAT = 21'h1FFFFF;
	localparam logic [24:0] HYST = 25'd104858;

	logic [23:0] thr_upper, thr_lower;
	logic [19:0] attack_len, hold_len, decay_len;
	logic [1:0] phase_q;
	logic [20:0] attack_cnt, hold_cnt, decay_cnt;
	logic [16:0] gain_q;
	ngate_pkg::out_word_t gated_q[$];

	function automatic logic [20:0] bump(input logic [20:0] c);
		return (c == CNT_SAT) ? c : c + 21'd1;
	endfunction

	function automatic logic [16:0] ratio_sq(input logic [20:0] n, input logic [19:0] d);
		logic [63:0] q;
		if (d == 0 || n >= d)
			return ngate_pkg::UNITY;
		q = ({43'd0, n} << 16) / d;
		return 17'((q * q) >> 16);
	endfunction

	task automatic enter_hold();
		phase_q = ngate_pkg::PH_HOLD;
		hold_cnt = 0;
		attack_cnt = 0;
		gain_q = ngate_pkg::UNITY;
	endtask

	task automatic gate_step(input ngate_pkg::in_word_t w);
		logic [24:0] rms;
		logic [20:0] dif;
		logic signed [63:0] prod;
		logic signed [63:0] res;
		ngate_pkg::out_word_t o;
		rms = 25'((48'(w.key_level) * 48'(ngate_pkg::RMS_SCALE)) >> 16);
		if (phase_q == ngate_pkg::PH_HOLD) begin
			if (rms > thr_lower)
				hold_cnt = 0;
			else if (hold_cnt < hold_len)
				hold_cnt = bump(hold_cnt);
			else begin
				phase_q = ngate_pkg::PH_DECAY;
				decay_cnt = 0;
			end
			gain_q = ngate_pkg::UNITY;
		end else if (phase_q == ngate_pkg::PH_DECAY) begin
			if (rms > thr_upper) begin
				if (attack_cnt > attack_len)
					enter_hold();
				else begin
					attack_cnt = bump(attack_cnt);
					decay_cnt = bump(decay_cnt);
					dif = (decay_cnt >= decay_len) ? decay_cnt - decay_len
						: 21'(decay_len) - decay_cnt;
					gain_q = ratio_sq(dif, decay_len);
				end
			end else if (decay_cnt > decay_len) begin
				phase_q = ngate_pkg::PH_IDLE;
				gain_q = 0;
			end else if (decay_cnt != 0) begin
				gain_q = ratio_sq(21'(decay_len) - decay_cnt, decay_len);
				decay_cnt = bump(decay_cnt);
			end else begin
				decay_cnt = bump(decay_cnt);
				gain_q = ngate_pkg::UNITY;
			end
		end else begin
			phase_q = ngate_pkg::PH_IDLE;
			if (rms < thr_upper && attack_cnt != 0)
				rms = rms + HYST;
			if (rms > thr_upper) begin
				if (attack_cnt > attack_len)
					enter_hold();
				else begin
					attack_cnt = bump(attack_cnt);
					gain_q = ratio_sq(attack_cnt, attack_len);
				end
			end else if (attack_cnt != 0) begin
				if (attack_cnt > hold_len)
					enter_hold();
				else begin
					phase_q = ngate_pkg::PH_DECAY;
					decay_cnt = attack_cnt;
					hold_cnt = 0;
					attack_cnt = 0;
					gain_q = ratio_sq(decay_cnt, attack_len);
				end
			end else
				gain_q = 0;
		end
		// >>> on signed product floors toward minus infinity
		prod = 64'(w.sample) * $signed({47'd0, gain_q});
		res = prod >>> 16;
		o.gated_sample = res[23:0];
		o.gain = gain_q;
		o.gate_state = phase_q;
		gated_q.push_back(o);
	endtask

	always @(posedge clk or negedge arst_n) begin
		ngate_pkg::out_word_t e;
		int errs;
		errs = 0;
		if (!arst_n) begin
			thr_upper = 0; thr_lower = 0;
			attack_len = 0; hold_len = 0; decay_len = 0;
			phase_q = ngate_pkg::PH_IDLE;
			attack_cnt = 0; hold_cnt = 0; decay_cnt = 0;
			gain_q = 0;
			gated_q.delete();
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				case (cfg.index)
					ngate_pkg::REG_UPPER: thr_upper = cfg.data[23:0];
					ngate_pkg::REG_LOWER: thr_lower = cfg.data[23:0];
					ngate_pkg::REG_ATTACK: attack_len = cfg.data[19:0];
					ngate_pkg::REG_HOLD: hold_len = cfg.data[19:0];
					ngate_pkg::REG_DECAY: decay_len = cfg.data[19:0];
					default: ;
				endcase
			if (out_valid && !out_stall) begin
				if (gated_q.size() == 0) begin
					$error("unexpected output word %h", out_data);
					errs++;
				end else begin
					e = gated_q.pop_front();
					if (out_data.gated_sample !== e.gated_sample) begin
						$error("gated_sample: expected %0d, got %0d",
							e.gated_sample, out_data.gated_sample);
						errs++;
					end
					if (out_data.gain !== e.gain) begin
						$error("gain: expected %0d, got %0d", e.gain, out_data.gain);
						errs++;
					end
					if (out_data.gate_state !== e.gate_state) begin
						$error("gate_state: expected %0d, got %0d",
							e.gate_state, out_data.gate_state);
						errs++;
					end
				end
			end
			if (in_valid && !in_stall)
				gate_step(in_data);
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
		pending <= gated_q.size();
	end
endmodule

### tb/tb.sv
// Testbench top: stimulus, configuration phases and verdict for the noise gate
`timescale 1ns / 100ps
module tb;
	localparam int STALL_LIMIT = 2000;
	// index past the register list, must be ignored
	localparam logic [2:0] REG_SPARE = 3'd7;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall;
	ngate_pkg::in_word_t in_data = '0;
	logic out_valid, out_stall = 0;
	ngate_pkg::out_word_t out_data;
	logic cfg_valid = 0, cfg_ready;
	ngate_pkg::cfg_word_t cfg = '0;
	int fail_count, pending;
	int idle_cycles = 0;
	bit timed_out = 0;
	int burst_left = 0;

	always #10 clk = ~clk;

	noise_gate_attack_hold_decay_top DUT (.*);

	gate_checker chk (.*);

	// receiver: stall pattern mode changes now and then
	int stall_mode = 0;
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
				|| !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic setup_gate(input logic [23:0] up, input logic [23:0] lo,
			input logic [19:0] att, input logic [19:0] hld, input logic [19:0] dec);
		// let the checker see the last accepted word before waiting on it
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		write_reg(ngate_pkg::REG_UPPER, {8'($urandom_range(0, 255)), up});
		write_reg(ngate_pkg::REG_LOWER, 32'(lo));
		write_reg(ngate_pkg::REG_ATTACK, {12'($urandom_range(0, 4095)), att});
		write_reg(ngate_pkg::REG_HOLD, 32'(hld));
		write_reg(ngate_pkg::REG_DECAY, 32'(dec));
		write_reg(REG_SPARE, $urandom);
	endtask

	// sender in bursts; valid held until accepted
	task automatic send_word(input logic [23:0] s, input logic [23:0] k);
		if (burst_left == 0) begin
			in_valid <= 0;
			if ($urandom_range(0, 2) != 0)
				repeat ($urandom_range(1, 40)) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end
		in_valid <= 1;
		in_data.sample <= s;
		in_data.key_level <= k;
		do @(posedge clk); while (in_stall);
		burst_left--;
	endtask

	task automatic end_send();
		in_valid <= 0;
		burst_left = 0;
	endtask

	// gate envelope: loud run then quiet run, random content
	task automatic envelope(input int n);
		int loud, quiet;
		for (int i = 0; i < n; i++) begin
			loud = $urandom_range(0, 25);
			quiet = $urandom_range(0, 30);
			repeat (loud)
				send_word(24'($urandom), 24'($urandom_range(24'h200000, 24'hFFFFFF)));
			repeat (quiet)
				send_word(24'($urandom), 24'($urandom_range(0, 24'h060000)));
			if ($urandom_range(0, 3) == 0)
				send_word(24'($urandom), 24'($urandom));
		end
		end_send();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// reset config: all zero thresholds and times
		send_word(24'h7FFFFF, 24'hFFFFFF);
		send_word(24'h800000, 24'h000000);
		send_word(24'hFFFFFF, 24'h000001);
		end_send();
		setup_gate(24'h100000, 24'h080000, 20'd4, 20'd3, 20'd5);
		// attack, hysteresis dip, hold, retrigger, decay, idle
		send_word(24'h7FFFFF, 24'h200000);
		send_word(24'h800000, 24'h200000);
		send_word(24'h123456, 24'h150000);
		send_word(24'h800000, 24'h200000);
		send_word(24'h7FFFFF, 24'h200000);
		send_word(24'h7FFFFF, 24'h200000);
		send_word(24'h400000, 24'h0C0000);
		send_word(24'hC00000, 24'h000000);
		send_word(24'h000001, 24'h000000);
		send_word(24'hFFFFFF, 24'h000000);
		send_word(24'h7FFFFF, 24'h000000);
		send_word(24'h800000, 24'h200000);
		send_word(24'h7FFFFF, 24'h000000);
		repeat (8) send_word(24'($urandom), 24'h000000);
		end_send();
		// zero attack and decay: unity gains
		setup_gate(24'h000000, 24'hFFFFFF, 20'd0, 20'd0, 20'd0);
		repeat (6) send_word(24'($urandom), 24'($urandom));
		end_send();
		setup_gate(24'hFFFFFF, 24'hFFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		repeat (6) send_word(24'($urandom), 24'hFFFFFF);
		end_send();
		for (int ph = 0; ph < 6; ph++) begin
			setup_gate(24'($urandom_range(24'h080000, 24'h180000)),
				24'($urandom_range(24'h040000, 24'h100000)),
				20'($urandom_range(0, 12)), 20'($urandom_range(0, 10)),
				20'($urandom_range(0, 15)));
			envelope(6);
		end
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
